[design/u8cp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cp_pkg
// Shared types, constants and decode functions of the UTF-8 to code point
// decoder.
// ----------------------------------------------------------------------------
package u8cp_pkg;

   localparam int unsigned CP_WIDTH   = 21;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned HOLD_DEPTH = 3;
   localparam int unsigned BUF_DEPTH  = HOLD_DEPTH + 1;

   // lead byte classes: mask and match per sequence length
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   // payload masks
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;
   localparam logic [7:0] CONT_BITS  = 8'h3F;

   // sequence lengths
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   typedef logic [CP_WIDTH-1:0]   cp_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [2:0]            len_type;
   typedef logic [1:0]            cnt_type;

   typedef struct packed {
      cnt_type count;
      cp_type  cp0;
      cp_type  cp1;
   } dec_result_type;

   // Length called for by a lead byte, LEN_NONE for a byte that is no lead
   function automatic len_type lead_length(input byte_type b);
      if ((b & ASCII_MASK) == 8'h00)       return LEN_ONE;
      if ((b & LEAD2_MASK) == LEAD2_CODE)  return LEN_TWO;
      if ((b & LEAD3_MASK) == LEAD3_CODE)  return LEN_THREE;
      if ((b & LEAD4_MASK) == LEAD4_CODE)  return LEN_FOUR;
      return LEN_NONE;
   endfunction

   // Decode a closed run of up to four bytes; keeps at most two nonzero
   // code points. An incomplete lead is dropped alone.
   function automatic dec_result_type decode_closed(
      input logic [BUF_DEPTH-1:0][BYTE_WIDTH-1:0] buf_b,
      input len_type                              len);
      dec_result_type res;
      len_type        nxt;
      len_type        n;
      cp_type         v;
      res = '0;
      nxt = '0;
      for (int p = 0; p < BUF_DEPTH; p++) begin
         if ((3'(p) < len) && (3'(p) >= nxt)) begin
            n = lead_length(buf_b[p]);
            v = '0;
            if (n == LEN_ONE) begin
               v   = cp_type'(buf_b[p]);
               nxt = 3'(p + 1);
            end else if ((n != LEN_NONE) && ((3'(p) + n) <= len)) begin
               case (n)
                  LEN_TWO:   v = cp_type'(buf_b[p] & LEAD2_BITS);
                  LEN_THREE: v = cp_type'(buf_b[p] & LEAD3_BITS);
                  default:   v = cp_type'(buf_b[p] & LEAD4_BITS);
               endcase
               for (int j = 1; j < BUF_DEPTH; j++) begin
                  if ((j < int'(n)) && ((p + j) < BUF_DEPTH)) begin
                     v = {v[CP_WIDTH-7:0], buf_b[2'(p + j)][5:0]};
                  end
               end
               nxt = 3'(p) + n;
            end else begin
               nxt = 3'(p + 1);
            end
            if ((v != '0) && (res.count != 2'd2)) begin
               if (res.count == 2'd0) begin
                  res.cp0 = v;
               end else begin
                  res.cp1 = v;
               end
               res.count = res.count + 2'd1;
            end
         end
      end
      return res;
   endfunction

endpackage

[design/utf8_to_codepoint_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_top
// Stream decoder from UTF-8 bytes to 21-bit code points.
// ----------------------------------------------------------------------------
// Takes one text byte per beat and returns decoded code points. A byte
// is accepted every cycle while the result side keeps up. The first result
// beat of a byte shows on the output once the byte has passed the input
// register and then the result register. A byte yields zero, one or (only at
// text end) two results; two results leave the output port one after the
// other, and the input register holds a next byte that yields a result until
// the second is being taken. Bytes that yield no result pass through without
// needing the output port. Continuation bytes are not checked, stray bytes and
// zero code points are dropped, and at text end an incomplete lead is dropped
// and the bytes held after it are decoded again.
module utf8_to_codepoint_decoder_top
   import u8cp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // final_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tuser,   // run_last
   output logic        rsp_tlast    // text_last
);

   // input register
   logic                              in_valid_ff, in_valid_in;
   byte_type                          in_byte_ff;
   logic                              in_final_ff;

   // held sequence state
   logic [HOLD_DEPTH-1:0][BYTE_WIDTH-1:0] held_ff, held_in;
   cnt_type                           hc_ff, hc_in;
   len_type                           seqlen_ff, seqlen_in;

   // result register, up to two code points
   cnt_type                           res_cnt_ff, res_cnt_in;
   cp_type                            res_cp0_ff, res_cp0_in;
   cp_type                            res_cp1_ff, res_cp1_in;
   logic                              res_fin_ff, res_fin_in;

   logic [BUF_DEPTH-1:0][BYTE_WIDTH-1:0] dec_buf;
   len_type                           dec_len;
   dec_result_type                    dec;
   len_type                           new_len;
   logic                              complete;
   logic                              emit_ok;
   cnt_type                           dec_cnt;
   logic                              res_free;
   logic                              advance;
   logic                              take;

   // closed buffer: held bytes followed by the new byte
   always_comb begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
         if (2'(i) < hc_ff && i < HOLD_DEPTH) begin
            dec_buf[i] = held_ff[2'(i)];
         end else if (3'(i) == {1'b0, hc_ff}) begin
            dec_buf[i] = in_byte_ff;
         end else begin
            dec_buf[i] = '0;
         end
      end
      dec_len = {1'b0, hc_ff} + 3'd1;
      dec     = decode_closed(dec_buf, dec_len);
   end

   // decode results are used unless the byte only extends a held sequence
   assign new_len  = lead_length(in_byte_ff);
   assign complete = (dec_len >= seqlen_ff) || (hc_ff == 2'd3);
   assign emit_ok  = in_final_ff || (hc_ff == 2'd0) || complete;
   assign dec_cnt  = emit_ok ? dec.count : 2'd0;

   // handshake
   assign take       = rsp_tvalid && rsp_tready;
   assign res_free   = (res_cnt_ff == 2'd0) || ((res_cnt_ff == 2'd1) && rsp_tready);
   assign advance    = in_valid_ff && (res_free || (dec_cnt == 2'd0));
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   // held state update
   always_comb begin
      held_in   = held_ff;
      hc_in     = hc_ff;
      seqlen_in = seqlen_ff;
      if (advance) begin
         if (in_final_ff) begin
            hc_in     = '0;
            seqlen_in = '0;
         end else if (hc_ff == 2'd0) begin
            if (new_len >= LEN_TWO) begin
               held_in[0] = in_byte_ff;
               hc_in      = 2'd1;
               seqlen_in  = new_len;
            end
         end else if (complete) begin
            hc_in     = '0;
            seqlen_in = '0;
         end else begin
            held_in[hc_ff] = in_byte_ff;
            hc_in          = hc_ff + 2'd1;
         end
      end
   end

   // result register load and drain
   always_comb begin
      res_cnt_in = res_cnt_ff;
      res_cp0_in = res_cp0_ff;
      res_cp1_in = res_cp1_ff;
      res_fin_in = res_fin_ff;
      if (advance && (dec_cnt != 2'd0)) begin
         res_cnt_in = dec_cnt;
         res_cp0_in = dec.cp0;
         res_cp1_in = dec.cp1;
         res_fin_in = in_final_ff;
      end else if (take) begin
         if (res_cnt_ff == 2'd2) begin
            res_cp0_in = res_cp1_ff;
            res_cnt_in = 2'd1;
         end else begin
            res_cnt_in = 2'd0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hc_ff       <= '0;
         seqlen_ff   <= '0;
         res_cnt_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         hc_ff       <= hc_in;
         seqlen_ff   <= seqlen_in;
         res_cnt_ff  <= res_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff  <= req_tdata;
         in_final_ff <= req_tlast;
      end
      held_ff    <= held_in;
      res_cp0_ff <= res_cp0_in;
      res_cp1_ff <= res_cp1_in;
      res_fin_ff <= res_fin_in;
   end

   // output beat
   assign rsp_tvalid = (res_cnt_ff != 2'd0);
   assign rsp_tdata  = {3'b000, res_cp0_ff};
   assign rsp_tuser  = (res_cnt_ff == 2'd1);
   assign rsp_tlast  = (res_cnt_ff == 2'd1) && res_fin_ff;

`ifndef SYNTHESIS
   // a held lead always waits for at least one more byte
   assert property (@(posedge clock) disable iff (reset)
      (hc_ff != 2'd0) |-> (seqlen_ff > {1'b0, hc_ff}))
      else $error("held sequence already complete");

   // a zero code point is never delivered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:0] != '0))
      else $error("zero code point on output");

   // after the first of two results goes, the second is shown as run end
   assert property (@(posedge clock) disable iff (reset)
      (take && (res_cnt_ff == 2'd2)) |=> (rsp_tvalid && rsp_tuser))
      else $error("second result of a pair lost");

   // text end only on the last result of a byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("text end without run end");
`endif

endmodule

[tb/sv/utf8_to_codepoint_decoder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_top_test
// Self-checking bench for the UTF-8 to code point stream decoder.
// ----------------------------------------------------------------------------
// Byte beats go in on the req side, and code point beats are checked on the
// rsp side against a local decoder model. Directed texts cover the byte
// classes, the sequence lengths, zero code points and early text ends. Random
// texts follow: mostly well-formed, the rest cut short, broken or noise.
// Both sides insert random gaps and stalls, with some stretches at full rate.
module utf8_to_codepoint_decoder_top_test
   import u8cp_pkg::*;
();

   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned RANDOM_BYTES = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct {
      cp_type cp;
      logic   run_last;
      logic   text_last;
   } cp_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] text_byte
   logic        req_tlast  = 1'b0;    // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [20:0] code_point, [23:21] zero
   logic        rsp_tuser;            // run_last
   logic        rsp_tlast;            // text_last

   // model state of the decoder
   byte_type    held_bytes_q[3];
   int          held_n   = 0;
   int          want_len = 0;

   cp_beat_type pending_cps[$];
   byte_type    text_bytes[$];

   bit          tx_gaps_on  = 1'b1;
   bit          rx_stall_on = 1'b1;
   int unsigned stall_left  = 0;
   int unsigned idle_cycles = 0;
   int unsigned err_count   = 0;
   int unsigned bytes_sent  = 0;
   int unsigned beats_checked = 0;
   int unsigned texts_closed  = 0;
   int unsigned pair_results  = 0;

   utf8_to_codepoint_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------------

   // sequence length announced by a byte, 0 for continuation or invalid
   function automatic int lead_len(input byte_type b);
      casez (b)
         8'b0???????: return 1;
         8'b110?????: return 2;
         8'b1110????: return 3;
         8'b11110???: return 4;
         default:     return 0;
      endcase
   endfunction

   // value of an n-byte sequence starting at s[at]; continuations masked only
   function automatic cp_type seq_value(input byte_type s[4], input int at, input int n);
      cp_type v;
      case (n)
         2:       v = cp_type'(s[at][4:0]);
         3:       v = cp_type'(s[at][3:0]);
         4:       v = cp_type'(s[at][2:0]);
         default: v = cp_type'(s[at]);
      endcase
      for (int i = 1; i < n; i++) begin
         v = {v[14:0], s[at + i][5:0]};
      end
      return v;
   endfunction

   // expected code point beats of one accepted byte, queued in order
   function automatic void predict_code_points(input byte_type b, input logic fin);
      byte_type    seq[4];
      cp_type      found[$];
      cp_type      kept[$];
      cp_beat_type beat;
      int          len;
      int          n;
      int          at;
      seq = '{default: 8'h00};
      if (fin) begin
         // closed text: held bytes plus this one, incomplete leads dropped alone
         for (int i = 0; i < held_n; i++) seq[i] = held_bytes_q[i];
         seq[held_n] = b;
         len = held_n + 1;
         at  = 0;
         while (at < len) begin
            n = lead_len(seq[at]);
            if (n == 1) begin
               found = {found, cp_type'(seq[at])};
               at++;
            end else if ((n >= 2) && (at + n <= len)) begin
               found = {found, seq_value(seq, at, n)};
               at += n;
            end else begin
               at++;
            end
         end
         held_n   = 0;
         want_len = 0;
      end else if (held_n == 0) begin
         n = lead_len(b);
         if (n == 1) begin
            found = {found, cp_type'(b)};
         end else if (n >= 2) begin
            held_bytes_q[0] = b;
            held_n   = 1;
            want_len = n;
         end
      end else if ((held_n + 1 >= want_len) || (held_n >= 3)) begin
         // byte completes the held sequence
         for (int i = 0; i < held_n; i++) seq[i] = held_bytes_q[i];
         seq[held_n] = b;
         found = {found, seq_value(seq, 0, held_n + 1)};
         held_n   = 0;
         want_len = 0;
      end else begin
         held_bytes_q[held_n] = b;
         held_n++;
      end

      // zero code points vanish, at most two beats per byte
      foreach (found[i]) begin
         if ((found[i] != '0) && (kept.size() < 2)) kept = {kept, found[i]};
      end
      foreach (kept[i]) begin
         beat.cp        = kept[i];
         beat.run_last  = (i == kept.size() - 1);
         beat.text_last = beat.run_last && fin;
         pending_cps    = {pending_cps, beat};
      end
      if (kept.size() == 2) pair_results++;
      if (fin) texts_closed++;
   endfunction

   // ------------------------------------------------------------------------
   // result side: stalls and checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      cp_beat_type want;
      int unsigned gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (pending_cps.size() == 0) begin
            $display("%0t: unexpected beat, got cp=%06h run_last=%b text_last=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            err_count++;
         end else begin
            want = pending_cps.pop_front();
            if (rsp_tdata !== {3'b000, want.cp}) begin
               $display("%0t: code_point mismatch, expected %06h, actual %06h",
                        $time, want.cp, rsp_tdata);
               err_count++;
            end
            if (rsp_tuser !== want.run_last) begin
               $display("%0t: run_last mismatch, expected %b, actual %b",
                        $time, want.run_last, rsp_tuser);
               err_count++;
            end
            if (rsp_tlast !== want.text_last) begin
               $display("%0t: text_last mismatch, expected %b, actual %b",
                        $time, want.text_last, rsp_tlast);
               err_count++;
            end
         end
         // stall drawn per result beat, zero keeps ready up
         gap = rx_stall_on ? $urandom_range(0, 14) : 0;
         stall_left <= gap;
         rsp_tready <= (gap == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // one byte beat, with a random gap ahead of it
   task automatic send_byte(input byte_type b, input logic fin);
      int unsigned gap;
      gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      predict_code_points(b, fin);
      bytes_sent++;
   endtask

   // send text_bytes, final flag on the last one if fin is set
   task automatic send_text(input logic fin);
      foreach (text_bytes[i]) begin
         send_byte(text_bytes[i], fin && (i == text_bytes.size() - 1));
      end
   endtask

   // append one byte to the text under construction
   function automatic void add_text_byte(input byte_type b);
      text_bytes = {text_bytes, b};
   endfunction

   // continuation byte, sometimes with garbage in the top bits
   function automatic byte_type cont_byte(input logic [5:0] bits);
      if ($urandom_range(0, 15) == 0) return {2'($urandom), bits};
      return {2'b10, bits};
   endfunction

   function automatic void append_random_char();
      logic [20:0] v;
      v = 21'($urandom);
      case ($urandom_range(1, 4))
         1: add_text_byte({1'b0, v[6:0]});
         2: begin
            add_text_byte({3'b110, v[10:6]});
            add_text_byte(cont_byte(v[5:0]));
         end
         3: begin
            add_text_byte({4'b1110, v[15:12]});
            add_text_byte(cont_byte(v[11:6]));
            add_text_byte(cont_byte(v[5:0]));
         end
         default: begin
            add_text_byte({5'b11110, v[20:18]});
            add_text_byte(cont_byte(v[17:12]));
            add_text_byte(cont_byte(v[11:6]));
            add_text_byte(cont_byte(v[5:0]));
         end
      endcase
   endfunction

   // zero byte, top ASCII and stray bytes outside any sequence
   task automatic test_single_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
   endtask

   // all sequence lengths, overlong zero, top code point, unchecked continuation
   task automatic test_multibyte_sequences();
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
   endtask

   // texts that end inside a sequence
   task automatic test_text_end();
      // dropped lead, stray left: no result and no flags
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      // dropped lead, two ASCII re-decoded, both kept
      send_byte(8'hF0, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      // dropped lead, one ASCII re-decoded
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b1);
   endtask

   task automatic test_random_texts();
      int unsigned start;
      int unsigned kind;
      logic        fin;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         tx_gaps_on  = ($urandom_range(0, 3) != 0);
         rx_stall_on <= ($urandom_range(0, 3) != 0);
         text_bytes.delete();
         fin  = 1'b1;
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            // well-formed text
            repeat ($urandom_range(1, 8)) append_random_char();
         end else if (kind < 80) begin
            // well-formed text cut short at a random byte
            repeat ($urandom_range(1, 8)) append_random_char();
            kind = $urandom_range(1, text_bytes.size());
            while (text_bytes.size() > kind) void'(text_bytes.pop_back());
         end else if (kind < 90) begin
            // byte from C0 to FF (a lead unless above F7), then up to three ASCII bytes and text end
            add_text_byte(8'hC0 | 8'($urandom_range(0, 63)));
            repeat ($urandom_range(0, 3)) add_text_byte(8'($urandom_range(1, 127)));
         end else begin
            // noise, text end optional
            repeat ($urandom_range(1, 6)) add_text_byte(8'($urandom));
            fin = 1'($urandom_range(0, 1));
         end
         send_text(fin);
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_single_bytes();
      test_multibyte_sequences();
      test_text_end();
      test_random_texts();

      req_tvalid <= 1'b0;
      while (pending_cps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d bytes sent, %0d texts closed, %0d code point beats checked",
               bytes_sent, texts_closed, beats_checked);
      $display("Run: %0d bytes gave two code points, %0d errors", pair_results, err_count);
      if (err_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
design/u8cp_pkg.sv
design/utf8_to_codepoint_decoder_top.sv
tb/sv/utf8_to_codepoint_decoder_top_test.sv
